FILE: rtl/core/ssesr_pkg.sv
// Shared types and constants for the sorted set with even swap readout.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package ssesr_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUMP      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DUMP   = 1'b1
  } op_t;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    status_t                 status;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

endpackage

FILE: rtl/core/ssesr_front.sv
// Front stage: accepts input items, decodes them into commands and holds one.
// Depends on ssesr_pkg; feeds ssesr_queue.
`timescale 1ns / 1ps

module ssesr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ssesr_pkg::in_item_t in_item,
  output logic                in_stall,
  output logic                push,
  output ssesr_pkg::cmd_t     push_cmd,
  input  logic                q_full
);
  import ssesr_pkg::*;

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_r, hold_nxt;
  logic take;

  assign push     = hold_valid_r && !q_full;
  assign in_stall = hold_valid_r && q_full;
  assign take     = in_valid && !in_stall;
  assign push_cmd = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (push) begin
      hold_valid_nxt = 1'b0;
    end
    if (take) begin
      hold_valid_nxt = 1'b1;
      hold_nxt.op    = op_t'(in_item.operation);
      // key carries no meaning for a dump
      hold_nxt.key   = (op_t'(in_item.operation) == OP_INSERT) ? in_item.key : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

FILE: rtl/core/ssesr_queue.sv
// Short command queue between front and back stages.
// Depends on ssesr_pkg.
`timescale 1ns / 1ps

module ssesr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ssesr_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output ssesr_pkg::cmd_t q_cmd
);
  import ssesr_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/ssesr_back.sv
// Back stage: entry cells, insert and dump sequencer, output register.
// Depends on ssesr_pkg; fed by ssesr_queue.
`timescale 1ns / 1ps

module ssesr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ssesr_pkg::cmd_t      q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ssesr_pkg::out_item_t out_item
);
  import ssesr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_DUMP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        step_r, step_nxt;
  logic signed [KEY_W-1:0] e_r [CAPACITY];
  logic signed [KEY_W-1:0] e_nxt [CAPACITY];
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] carry_r, carry_nxt;
  logic [CAPACITY-1:0]     ge_r, ge_nxt;
  logic [CAPACITY-1:0]     eq_r, eq_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  logic                    adv;
  logic [CAPACITY-1:0]     cmp_ge, cmp_eq;
  logic [CAPACITY-1:0]     prior, after, first;
  logic                    dup, full;
  logic signed [KEY_W-1:0] prev_e [CAPACITY];
  logic signed [KEY_W-1:0] ins_e [CAPACITY];
  logic signed [KEY_W-1:0] fwd_e [CAPACITY];
  logic signed [KEY_W-1:0] dump_val;
  logic [CNT_W-1:0]        tail;

  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign tail      = cnt_r - 1'b1;

  // cell compares: slots past the count read as "not less"
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cmp_ge[k] = (CNT_W'(k) >= cnt_r) || !(e_r[k] < key_r);
      cmp_eq[k] = (CNT_W'(k) < cnt_r) && (e_r[k] == key_r);
    end
  end

  // insertion point from the registered compare vector
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      prior[k] = |(ge_r & ~({CAPACITY{1'b1}} << k));
      after[k] = prior[k] | ge_r[k];
      first[k] = ge_r[k] & ~prior[k];
    end
    dup = |(first & eq_r);
    prev_e[0] = key_r;
    for (int k = 1; k < CAPACITY; k++) begin
      prev_e[k] = e_r[k-1];
    end
    for (int k = 0; k < CAPACITY; k++) begin
      if (!after[k]) begin
        ins_e[k] = e_r[k];
      end else if (first[k]) begin
        ins_e[k] = key_r;
      end else begin
        ins_e[k] = prev_e[k];
      end
    end
  end

  // dump: the head leaves each cycle that the output can advance, the finished value enters at the tail
  always_comb begin
    if (step_r == cnt_r) begin
      dump_val = carry_r;
    end else if (!e_r[0][0]) begin
      dump_val = e_r[0];
    end else begin
      dump_val = carry_r;
    end
    for (int k = 0; k < CAPACITY - 1; k++) begin
      fwd_e[k] = (CNT_W'(k) == tail) ? dump_val : e_r[k+1];
    end
    fwd_e[CAPACITY-1] = (CNT_W'(CAPACITY - 1) == tail) ? dump_val : e_r[CAPACITY-1];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    e_nxt         = e_r;
    key_nxt       = key_r;
    carry_nxt     = carry_r;
    ge_nxt        = ge_r;
    eq_nxt        = eq_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    if (adv) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && adv) begin
          q_pop   = 1'b1;
          key_nxt = q_cmd.key;
          if (q_cmd.op == OP_INSERT) begin
            state_nxt = S_CMP;
          end else if (cnt_r == '0) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.value  = '0;
            out_item_nxt.status = ST_EMPTY;
            out_item_nxt.last   = 1'b1;
          end else begin
            step_nxt  = '0;
            state_nxt = S_DUMP;
          end
        end
      end
      S_CMP: begin
        ge_nxt    = cmp_ge;
        eq_nxt    = cmp_eq;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (adv) begin
          out_valid_nxt      = 1'b1;
          out_item_nxt.value = '0;
          out_item_nxt.last  = 1'b1;
          if (dup) begin
            out_item_nxt.status = ST_DUPLICATE;
          end else if (full) begin
            out_item_nxt.status = ST_FULL;
          end else begin
            out_item_nxt.status = ST_INSERTED;
            e_nxt               = ins_e;
            cnt_nxt             = cnt_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (adv) begin
          e_nxt = fwd_e;
          if (step_r == '0) begin
            carry_nxt = e_r[0];
          end else begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.value  = dump_val;
            out_item_nxt.status = ST_DUMP;
            out_item_nxt.last   = (step_r == cnt_r);
            if (step_r != cnt_r && e_r[0][0]) begin
              carry_nxt = e_r[0];
            end
          end
          if (step_r == cnt_r) begin
            state_nxt = S_IDLE;
          end
          step_nxt = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    e_r        <= e_nxt;
    key_r      <= key_nxt;
    carry_r    <= carry_nxt;
    ge_r       <= ge_nxt;
    eq_r       <= eq_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

FILE: rtl/core/sorted_set_with_even_swap_readout.sv
// Sorted set of up to CAPACITY signed keys with an even swap readout.
// Insert: the command passes the front holding register and the command queue, then the
// back states pop, cell compare and update; the back takes no new command until it is done.
// Dump of n entries: after the pop, a first dump step loads the carry, then one entry
// out per cycle while out_stall allows; an empty dump registers its result at the pop.
// Reset (rst_n low, synchronous): entry count, queue and output valid clear;
// entry cells are not reset and are only read below the count.
`timescale 1ns / 1ps

module sorted_set_with_even_swap_readout (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  ssesr_pkg::in_item_t  in_item,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ssesr_pkg::out_item_t out_item
);
  import ssesr_pkg::*;

  // front -> queue
  logic push;
  cmd_t push_cmd;
  logic q_full;
  // queue -> back
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // Front: takes one item per cycle when its holding register can drain.
  ssesr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // Two-entry command queue so the front can keep taking items during a dump until it fills.
  ssesr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Back: cells compare the key in parallel; a dump rotates the cells once,
  // swapping each even value forward by one as it passes the head.
  ssesr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef ASSERT_OFF
  // the back never pops an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty command queue");

  // front never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("push into full command queue");

  // insert and empty results carry a zero value and always close the item
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_item.status != ST_DUMP) |-> (out_item.value == '0 && out_item.last))
    else $error("non-dump result with value or without last");

  // status codes stay within the defined set
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_item.status <= ST_EMPTY))
    else $error("undefined status code");
`endif

endmodule
